[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers, sampled on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define QPR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define QPR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/qpr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpr_pkg
// Shared constants and types for the quaternion point rotation block.
// ----------------------------------------------------------------------------
package qpr_pkg;

  localparam int COORD_WIDTH_DEF    = 24;
  localparam int QUAT_FRAC_BITS_DEF = 14;

  // Quaternion registers are fixed at 16 bits, signed.
  localparam int QUAT_WIDTH  = 16;
  localparam int CFG_INDEX_W = 2;

  localparam logic signed [QUAT_WIDTH-1:0] QUAT_W_RESET = 16'sd16384;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_QUAT_W = 2'd0,
    REG_QUAT_X = 2'd1,
    REG_QUAT_Y = 2'd2,
    REG_QUAT_Z = 2'd3
  } cfg_reg_t;

endpackage

[hw/rtl/quaternion_point_rotate.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_point_rotate
// Rotates a stream of 3D points by a unit quaternion held in registers.
// ----------------------------------------------------------------------------
// Usage:
//   Points arrive on the s_axis channel, one point per transaction, and the
//   rotated point leaves on the m_axis channel with the clip flag in tuser.
//   The quaternion (w, x, y, z) is written through cfg_we / cfg_index /
//   cfg_data and should only change while no point is in flight.
//   A result is on m_axis_tvalid once its input transaction has been accepted
//   and has passed through the register stages listed below. Throughput is
//   one point per cycle while the output is not stalled.
//   The pipeline has five register stages: the first cross product and w*p
//   multipliers, the t sum, the second cross product multipliers, the final
//   wide sum with rounding offset, and the saturating output register.
//   When the receiver holds m_axis_tready low with a result waiting, all
//   stages freeze together and s_axis_tready drops; nothing is lost or
//   duplicated, and bubbles further up are not squeezed out during a stall.
//   Reset clears all valid bits and loads the identity quaternion
//   (w = 1.0, x = y = z = 0).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quaternion_point_rotate #(
  parameter int COORD_WIDTH    = qpr_pkg::COORD_WIDTH_DEF,
  parameter int QUAT_FRAC_BITS = qpr_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  // Configuration write port.
  input  logic                                     cfg_we,
  input  logic [qpr_pkg::CFG_INDEX_W-1:0]          cfg_index,
  input  logic [qpr_pkg::QUAT_WIDTH-1:0]           cfg_data,
  // Input points.
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // tdata: point_x, point_y, point_z (from bit 0 up), zero padded.
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
  // Rotated points.
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // tdata: rotated_x, rotated_y, rotated_z (from bit 0 up), zero padded.
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]       m_axis_tdata,
  // tuser: saturated.
  output logic                                     m_axis_tuser
);

  import qpr_pkg::*;

  localparam int CW      = COORD_WIDTH;
  localparam int F2      = 2 * QUAT_FRAC_BITS;
  localparam int TDATA_W = ((3*COORD_WIDTH+7)/8)*8;
  localparam int PW      = CW + QUAT_WIDTH;          // q * p
  localparam int TW      = PW + 2;                   // t = a - b + w*p
  localparam int DPW     = TW + QUAT_WIDTH;          // q * t
  localparam int SHW     = (F2 > DPW + 2 - CW) ? F2 : (DPW + 2 - CW);
  localparam int SW      = CW + SHW + 2;             // final sum width

  localparam logic signed [SW-1:0] HALF    = SW'(1) <<< (F2 - 1);
  localparam logic signed [CW-1:0] MAX_VAL = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MIN_VAL = {1'b1, {(CW-1){1'b0}}};

  // Quaternion registers.
  logic signed [QUAT_WIDTH-1:0] quat_w;
  logic signed [QUAT_WIDTH-1:0] quat_x;
  logic signed [QUAT_WIDTH-1:0] quat_y;
  logic signed [QUAT_WIDTH-1:0] quat_z;
  logic signed [QUAT_WIDTH-1:0] qv [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      quat_w <= QUAT_W_RESET;
      quat_x <= '0;
      quat_y <= '0;
      quat_z <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_QUAT_W: quat_w <= cfg_data;
        REG_QUAT_X: quat_x <= cfg_data;
        REG_QUAT_Y: quat_y <= cfg_data;
        REG_QUAT_Z: quat_z <= cfg_data;
        default: ;
      endcase
    end
  end

  assign qv[0] = quat_x;
  assign qv[1] = quat_y;
  assign qv[2] = quat_z;

  // Pipeline control: every stage moves together unless a result is stuck.
  logic en;
  logic v1, v2, v3, v4, v5;

  assign en            = !v5 || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Stage payloads.
  logic signed [CW-1:0]  pin [0:2];
  logic signed [CW-1:0]  p1  [0:2];
  logic signed [CW-1:0]  p2  [0:2];
  logic signed [CW-1:0]  p3  [0:2];
  logic signed [PW-1:0]  ma1 [0:2];
  logic signed [PW-1:0]  mb1 [0:2];
  logic signed [PW-1:0]  mw1 [0:2];
  logic signed [TW-1:0]  t2  [0:2];
  logic signed [DPW-1:0] da3 [0:2];
  logic signed [DPW-1:0] db3 [0:2];
  logic signed [SW-1:0]  s4  [0:2];
  logic signed [CW-1:0]  rot [0:2];
  logic                  clip [0:2];
  logic                  sat_out;
  logic                  any_bound;

  for (genvar g = 0; g < 3; g++) begin : g_axis
    localparam int G1 = (g + 1) % 3;
    localparam int G2 = (g + 2) % 3;

    logic [SW-1-(F2+CW-1):0] hi_bits;
    logic                    in_range;

    assign pin[g] = s_axis_tdata[g*CW +: CW];

    always_ff @(posedge clk) begin
      if (en) begin
        // Stage 1: terms of qv x p and w * p.
        p1[g]  <= pin[g];
        ma1[g] <= PW'(qv[G1]) * PW'(pin[G2]);
        mb1[g] <= PW'(qv[G2]) * PW'(pin[G1]);
        mw1[g] <= PW'(quat_w) * PW'(pin[g]);
        // Stage 2: t = qv x p + w * p, exact at scale 2^F.
        p2[g]  <= p1[g];
        t2[g]  <= TW'(ma1[g]) - TW'(mb1[g]) + TW'(mw1[g]);
        // Stage 3: terms of qv x t.
        p3[g]  <= p2[g];
        da3[g] <= DPW'(qv[G1]) * DPW'(t2[G2]);
        db3[g] <= DPW'(qv[G2]) * DPW'(t2[G1]);
        // Stage 4: p * 2^(2F) + 2 * (qv x t) plus the rounding offset.
        s4[g]  <= (SW'(p3[g]) <<< F2) + ((SW'(da3[g]) - SW'(db3[g])) <<< 1) + HALF;
      end
    end

    // The rounded value is in range when every bit above its sign agrees.
    assign hi_bits  = s4[g][SW-1:F2+CW-1];
    assign in_range = (&hi_bits) || !(|hi_bits);
    assign clip[g]  = !in_range;

    always_ff @(posedge clk) begin
      if (en) begin
        if (in_range) begin
          rot[g] <= s4[g][F2 +: CW];
        end else begin
          rot[g] <= s4[g][SW-1] ? MIN_VAL : MAX_VAL;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat_out <= clip[0] || clip[1] || clip[2];
    end
  end

  assign m_axis_tvalid = v5;
  assign m_axis_tdata  = TDATA_W'({rot[2], rot[1], rot[0]});
  assign m_axis_tuser  = sat_out;

  assign any_bound = rot[0] == MAX_VAL || rot[0] == MIN_VAL ||
                     rot[1] == MAX_VAL || rot[1] == MIN_VAL ||
                     rot[2] == MAX_VAL || rot[2] == MIN_VAL;

  `QPR_ASSERT_NXT(a_stall_holds, !en, $stable({v1, v2, v3, v4, v5}), "valid bits moved during a stall")
  `QPR_ASSERT_NXT(a_last_stage, en, v5 == $past(v4), "output valid does not follow stage 4")
  `QPR_ASSERT_IMP(a_sat_bound, v5 && sat_out, any_bound, "saturated flag without a clipped coordinate")

endmodule
